/* rtl/core/srtf_pkg.sv */
// shared types and constants for the srtf scheduler
// no dependencies
`default_nettype none
package srtf_pkg;

    // internal tick width: latest arrival plus all bursts never wraps
    localparam int TICK_W = 17;
    localparam int ARR_W  = 15;
    localparam int BUR_W  = 11;

    typedef enum logic [1:0] {
        KIND_SEG = 2'd0,
        KIND_MET = 2'd1,
        KIND_AVG = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FLUSH,
        ST_MET,
        ST_DIV,
        ST_AVG
    } t_state;

    // one process entry as kept in the table memory
    typedef struct packed {
        logic [ARR_W-1:0]  arrival;
        logic [BUR_W-1:0]  burst;
        logic [BUR_W-1:0]  remaining;
        logic              started;
        logic [TICK_W-1:0] first_run;
        logic [TICK_W-1:0] completion;
    } t_row;

endpackage
`default_nettype wire

/* rtl/core/srtf_ram.sv */
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none
module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/srtf_div.sv */
// restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none
module srtf_div #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd, n_dvd;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   trial;

    always_comb begin
        rem_sh = {r_rem, r_dvd[DVD_W-1]};
        trial  = rem_sh - {1'b0, r_dvs};
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_cnt  = CNT_W'(DVD_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // quotient bits shift in from the bottom as dividend bits leave the top
            if (rem_sh >= {1'b0, r_dvs}) begin
                n_rem = trial[DVS_W-1:0];
                n_dvd = {r_dvd[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DVS_W-1:0];
                n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule
`default_nettype wire

/* rtl/core/srtf_preemptive_scheduler.sv */
// top level of the preemptive shortest-remaining-time-first scheduler
// uses srtf_pkg, srtf_ram and srtf_div
//
// Processes are loaded one per cycle while o_busy is low: each accepted item
// (i_start high, o_busy low) stores one process in the table memory, unless
// MAX_PROCS are already held. The item with i_final_process set starts the run
// and raises o_busy until the last result. One simulated tick is a full read
// pass over the n loaded entries through the single memory read port, then an
// update in ST_DECIDE; an idle gap costs one such pass. Results come one per
// o_valid pulse and cannot be stalled: run segments, then one metrics result
// per process, then the averages after a divider pass, flagged o_last_result.
`default_nettype none
module srtf_preemptive_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic [14:0]          i_arrival,
    input  wire logic [10:0]          i_burst,
    input  wire logic                 i_final_process,
    output logic                      o_valid,
    output srtf_pkg::t_kind           o_kind,
    output logic      [3:0]           o_proc_index,
    output logic      [15:0]          o_seg_start,
    output logic      [15:0]          o_seg_end,
    output logic      [14:0]          o_arrival_out,
    output logic      [10:0]          o_burst_out,
    output logic      [15:0]          o_completion,
    output logic      [23:0]          o_turnaround,
    output logic      [23:0]          o_waiting,
    output logic      [23:0]          o_response,
    output logic                      o_last_result
);
    import srtf_pkg::*;

    localparam int IW  = $clog2(MAX_PROCS);
    localparam int CW  = $clog2(MAX_PROCS + 1);
    localparam int SW  = TICK_W + CW;
    localparam int DVW = SW + 8;
    localparam int RW  = $bits(t_row);

    t_state r_state, n_state;

    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_done_cnt, n_done_cnt;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [TICK_W-1:0] r_seg_begin, n_seg_begin;
    logic              r_run_vld, n_run_vld;
    logic [IW-1:0]     r_run_idx, n_run_idx;
    logic              r_init, n_init;

    // read pass over the table
    logic [CW-1:0]     r_ridx, n_ridx;
    logic              r_pvld, n_pvld;
    logic [IW-1:0]     r_pidx, n_pidx;
    logic              scan_end;

    logic              r_sel_vld, n_sel_vld;
    logic [IW-1:0]     r_sel_idx, n_sel_idx;
    t_row              r_sel_row, n_sel_row;
    logic              r_next_vld, n_next_vld;
    logic [ARR_W-1:0]  r_next, n_next;

    logic [SW-1:0]     r_sum_t, n_sum_t;
    logic [SW-1:0]     r_sum_w, n_sum_w;
    logic [SW-1:0]     r_sum_r, n_sum_r;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    t_row              ram_wdata;
    t_row              ram_rdata;
    logic [RW-1:0]     ram_rbits;

    logic              div_start;
    logic              div_done;
    logic              div_done_t, div_done_w, div_done_r;
    logic [DVW-1:0]    q_t, q_w, q_r;

    // output registers
    logic              r_valid, n_valid;
    t_kind             r_kind, n_kind;
    logic [3:0]        r_idx, n_idx;
    logic [15:0]       r_segs, n_segs;
    logic [15:0]       r_sege, n_sege;
    logic [14:0]       r_arr_o, n_arr_o;
    logic [10:0]       r_bur_o, n_bur_o;
    logic [15:0]       r_comp_o, n_comp_o;
    logic [23:0]       r_ta_o, n_ta_o;
    logic [23:0]       r_wt_o, n_wt_o;
    logic [23:0]       r_rs_o, n_rs_o;
    logic              r_last, n_last;

    // datapath terms
    logic              load_ok;
    logic [BUR_W-1:0]  load_bur;
    logic              d_active;
    logic              d_ready;
    logic              d_better;
    logic [BUR_W-1:0]  sel_rem_dec;
    logic              sel_finishes;
    logic [TICK_W-1:0] m_ta;
    logic [TICK_W-1:0] m_wt;
    logic [TICK_W-1:0] m_rs;

    srtf_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ridx[IW-1:0]),
        .o_rdata (ram_rbits)
    );
    assign ram_rdata = t_row'(ram_rbits);

    srtf_div #(.DVD_W(DVW), .DVS_W(CW)) u_div_t (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (div_start),
        .i_dividend ({r_sum_t, 8'd0}), .i_divisor (r_count),
        .o_done (div_done_t), .o_quot (q_t)
    );
    srtf_div #(.DVD_W(DVW), .DVS_W(CW)) u_div_w (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (div_start),
        .i_dividend ({r_sum_w, 8'd0}), .i_divisor (r_count),
        .o_done (div_done_w), .o_quot (q_w)
    );
    srtf_div #(.DVD_W(DVW), .DVS_W(CW)) u_div_r (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (div_start),
        .i_dividend ({r_sum_r, 8'd0}), .i_divisor (r_count),
        .o_done (div_done_r), .o_quot (q_r)
    );
    assign div_done = div_done_t & div_done_w & div_done_r;

    assign scan_end     = (r_ridx == r_count) && !r_pvld;
    assign load_ok      = r_count < CW'(MAX_PROCS);
    assign load_bur     = (i_burst == '0) ? BUR_W'(1) : i_burst;
    assign d_active     = ram_rdata.remaining != '0;
    assign d_ready      = d_active && ({2'b00, ram_rdata.arrival} <= r_tick);
    assign d_better     = !r_sel_vld
                          || (ram_rdata.remaining < r_sel_row.remaining)
                          || ((ram_rdata.remaining == r_sel_row.remaining)
                              && (ram_rdata.arrival < r_sel_row.arrival));
    assign sel_rem_dec  = r_sel_row.remaining - 1'b1;
    assign sel_finishes = sel_rem_dec == '0;
    assign m_ta         = ram_rdata.completion - {2'b00, ram_rdata.arrival};
    assign m_wt         = m_ta - {6'd0, ram_rdata.burst};
    assign m_rs         = ram_rdata.first_run - {2'b00, ram_rdata.arrival};
    assign div_start    = (r_state == ST_MET) && scan_end;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && i_final_process) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!r_init && r_sel_vld && sel_finishes
                    && (r_done_cnt + 1'b1 == r_count)) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_FLUSH: n_state = ST_MET;
            ST_MET: begin
                if (scan_end) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_AVG;
                end
            end
            ST_AVG:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and results
    always_comb begin
        n_count     = r_count;
        n_done_cnt  = r_done_cnt;
        n_tick      = r_tick;
        n_seg_begin = r_seg_begin;
        n_run_vld   = r_run_vld;
        n_run_idx   = r_run_idx;
        n_init      = r_init;
        n_ridx      = r_ridx;
        n_pvld      = 1'b0;
        n_pidx      = r_pidx;
        n_sel_vld   = r_sel_vld;
        n_sel_idx   = r_sel_idx;
        n_sel_row   = r_sel_row;
        n_next_vld  = r_next_vld;
        n_next      = r_next;
        n_sum_t     = r_sum_t;
        n_sum_w     = r_sum_w;
        n_sum_r     = r_sum_r;
        ram_we      = 1'b0;
        ram_waddr   = r_count[IW-1:0];
        ram_wdata   = r_sel_row;
        n_valid     = 1'b0;
        n_kind      = KIND_SEG;
        n_idx       = '0;
        n_segs      = '0;
        n_sege      = '0;
        n_arr_o     = '0;
        n_bur_o     = '0;
        n_comp_o    = '0;
        n_ta_o      = '0;
        n_wt_o      = '0;
        n_rs_o      = '0;
        n_last      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (load_ok) begin
                        ram_we               = 1'b1;
                        ram_wdata.arrival    = i_arrival;
                        ram_wdata.burst      = load_bur;
                        ram_wdata.remaining  = load_bur;
                        ram_wdata.started    = 1'b0;
                        ram_wdata.first_run  = '0;
                        ram_wdata.completion = '0;
                        n_count              = r_count + 1'b1;
                    end
                    if (i_final_process) begin
                        n_init     = 1'b1;
                        n_ridx     = '0;
                        n_sel_vld  = 1'b0;
                        n_next_vld = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                if (r_ridx != r_count) begin
                    n_pvld = 1'b1;
                    n_pidx = r_ridx[IW-1:0];
                    n_ridx = r_ridx + 1'b1;
                end
                if (r_pvld) begin
                    if (d_ready && d_better) begin
                        n_sel_vld = 1'b1;
                        n_sel_idx = r_pidx;
                        n_sel_row = ram_rdata;
                    end
                    if (d_active && (!r_next_vld || ram_rdata.arrival < r_next)) begin
                        n_next_vld = 1'b1;
                        n_next     = ram_rdata.arrival;
                    end
                end
            end
            ST_DECIDE: begin
                n_ridx     = '0;
                n_sel_vld  = 1'b0;
                n_next_vld = 1'b0;
                if (r_init || !r_sel_vld) begin
                    // nothing ready: close any open segment and jump ahead
                    if (!r_init && r_run_vld) begin
                        n_valid = 1'b1;
                        n_kind  = KIND_SEG;
                        n_idx   = 4'(r_run_idx);
                        n_segs  = r_seg_begin[15:0];
                        n_sege  = r_tick[15:0];
                    end
                    n_init      = 1'b0;
                    n_run_vld   = 1'b0;
                    n_tick      = {2'b00, r_next};
                    n_seg_begin = {2'b00, r_next};
                end else begin
                    ram_we              = 1'b1;
                    ram_waddr           = r_sel_idx;
                    ram_wdata.remaining = sel_rem_dec;
                    if (!r_sel_row.started) begin
                        ram_wdata.started   = 1'b1;
                        ram_wdata.first_run = r_tick;
                    end
                    if (sel_finishes) begin
                        ram_wdata.completion = r_tick + 1'b1;
                        n_done_cnt           = r_done_cnt + 1'b1;
                    end
                    if (!r_run_vld || (r_run_idx != r_sel_idx)) begin
                        if (r_run_vld) begin
                            n_valid = 1'b1;
                            n_kind  = KIND_SEG;
                            n_idx   = 4'(r_run_idx);
                            n_segs  = r_seg_begin[15:0];
                            n_sege  = r_tick[15:0];
                        end
                        n_seg_begin = r_tick;
                        n_run_vld   = 1'b1;
                        n_run_idx   = r_sel_idx;
                    end
                    n_tick = r_tick + 1'b1;
                end
            end
            ST_FLUSH: begin
                if (r_run_vld) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_SEG;
                    n_idx   = 4'(r_run_idx);
                    n_segs  = r_seg_begin[15:0];
                    n_sege  = r_tick[15:0];
                end
                n_run_vld = 1'b0;
                n_ridx    = '0;
                n_sum_t   = '0;
                n_sum_w   = '0;
                n_sum_r   = '0;
            end
            ST_MET: begin
                if (r_ridx != r_count) begin
                    n_pvld = 1'b1;
                    n_pidx = r_ridx[IW-1:0];
                    n_ridx = r_ridx + 1'b1;
                end
                if (r_pvld) begin
                    n_valid  = 1'b1;
                    n_kind   = KIND_MET;
                    n_idx    = 4'(r_pidx);
                    n_arr_o  = ram_rdata.arrival;
                    n_bur_o  = ram_rdata.burst;
                    n_comp_o = ram_rdata.completion[15:0];
                    n_ta_o   = 24'(m_ta);
                    n_wt_o   = 24'(m_wt);
                    n_rs_o   = 24'(m_rs);
                    n_sum_t  = r_sum_t + SW'(m_ta);
                    n_sum_w  = r_sum_w + SW'(m_wt);
                    n_sum_r  = r_sum_r + SW'(m_rs);
                end
            end
            ST_DIV: begin
            end
            ST_AVG: begin
                n_valid     = 1'b1;
                n_kind      = KIND_AVG;
                n_ta_o      = q_t[23:0];
                n_wt_o      = q_w[23:0];
                n_rs_o      = q_r[23:0];
                n_last      = 1'b1;
                // batch closed: back to an empty table
                n_count     = '0;
                n_done_cnt  = '0;
                n_tick      = '0;
                n_seg_begin = '0;
                n_run_vld   = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_done_cnt  <= '0;
            r_tick      <= '0;
            r_seg_begin <= '0;
            r_run_vld   <= 1'b0;
            r_init      <= 1'b0;
            r_ridx      <= '0;
            r_pvld      <= 1'b0;
            r_sel_vld   <= 1'b0;
            r_next_vld  <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_done_cnt  <= n_done_cnt;
            r_tick      <= n_tick;
            r_seg_begin <= n_seg_begin;
            r_run_vld   <= n_run_vld;
            r_init      <= n_init;
            r_ridx      <= n_ridx;
            r_pvld      <= n_pvld;
            r_sel_vld   <= n_sel_vld;
            r_next_vld  <= n_next_vld;
            r_valid     <= n_valid;
        end
        r_run_idx <= n_run_idx;
        r_pidx    <= n_pidx;
        r_sel_idx <= n_sel_idx;
        r_sel_row <= n_sel_row;
        r_next    <= n_next;
        r_sum_t   <= n_sum_t;
        r_sum_w   <= n_sum_w;
        r_sum_r   <= n_sum_r;
        r_kind    <= n_kind;
        r_idx     <= n_idx;
        r_segs    <= n_segs;
        r_sege    <= n_sege;
        r_arr_o   <= n_arr_o;
        r_bur_o   <= n_bur_o;
        r_comp_o  <= n_comp_o;
        r_ta_o    <= n_ta_o;
        r_wt_o    <= n_wt_o;
        r_rs_o    <= n_rs_o;
        r_last    <= n_last;
    end

    assign o_busy        = r_state != ST_IDLE;
    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_proc_index  = r_idx;
    assign o_seg_start   = r_segs;
    assign o_seg_end     = r_sege;
    assign o_arrival_out = r_arr_o;
    assign o_burst_out   = r_bur_o;
    assign o_completion  = r_comp_o;
    assign o_turnaround  = r_ta_o;
    assign o_waiting     = r_wt_o;
    assign o_response    = r_rs_o;
    assign o_last_result = r_last;

endmodule
`default_nettype wire

/* dv/srtf_preemptive_scheduler_tb.sv */
// self-checking testbench for the srtf preemptive scheduler
// depends on srtf_pkg and the srtf_preemptive_scheduler top level
// predicts segments, per-process metrics and averages for each loaded batch
module srtf_preemptive_scheduler_tb;
    import srtf_pkg::*;

    localparam int NPROC = 16;

    typedef struct {
        t_kind       kind;
        logic [3:0]  idx;
        logic [15:0] seg_b;
        logic [15:0] seg_e;
        logic [14:0] arr;
        logic [10:0] bur;
        logic [15:0] comp;
        logic [23:0] ta;
        logic [23:0] wt;
        logic [23:0] rs;
        logic        last;
    } t_sched_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic [14:0] i_arrival;
    logic [10:0] i_burst;
    logic        i_final_process;
    logic        o_busy;
    logic        o_valid;
    t_kind       o_kind;
    logic [3:0]  o_proc_index;
    logic [15:0] o_seg_start;
    logic [15:0] o_seg_end;
    logic [14:0] o_arrival_out;
    logic [10:0] o_burst_out;
    logic [15:0] o_completion;
    logic [23:0] o_turnaround;
    logic [23:0] o_waiting;
    logic [23:0] o_response;
    logic        o_last_result;

    t_sched_res sched_q[$];
    int         proc_arr[NPROC];
    int         proc_bur[NPROC];
    int         n_loaded;
    int         n_errors;

    srtf_preemptive_scheduler #(.MAX_PROCS(NPROC)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_arrival(i_arrival), .i_burst(i_burst), .i_final_process(i_final_process),
        .o_valid(o_valid), .o_kind(o_kind), .o_proc_index(o_proc_index),
        .o_seg_start(o_seg_start), .o_seg_end(o_seg_end),
        .o_arrival_out(o_arrival_out), .o_burst_out(o_burst_out),
        .o_completion(o_completion), .o_turnaround(o_turnaround),
        .o_waiting(o_waiting), .o_response(o_response),
        .o_last_result(o_last_result)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    function automatic void push_segment(int p, int b, int e);
        t_sched_res r;
        r = '{kind: KIND_SEG, default: '0};
        r.idx   = p[3:0];
        r.seg_b = b[15:0];
        r.seg_e = e[15:0];
        sched_q.insert(sched_q.size(), r);
    endfunction

    // unit-tick shortest-remaining-time run over the loaded batch
    function automatic void schedule_batch();
        int rem[NPROC];
        int first[NPROC];
        int comp[NPROC];
        int cur, running, seg_b, done, sel, nxt, n;
        longint sum_t, sum_w, sum_r;
        t_sched_res r;
        n = n_loaded;
        cur = proc_arr[0];
        for (int i = 0; i < n; i++) begin
            rem[i] = proc_bur[i];
            first[i] = -1;
            if (proc_arr[i] < cur) cur = proc_arr[i];
        end
        running = -1;
        seg_b = cur;
        done = 0;
        while (done < n) begin
            sel = -1;
            for (int i = 0; i < n; i++) begin
                if (rem[i] == 0 || proc_arr[i] > cur) continue;
                if (sel < 0 || rem[i] < rem[sel]) sel = i;
                else if (rem[i] == rem[sel] && proc_arr[i] < proc_arr[sel]) sel = i;
            end
            if (sel < 0) begin
                // idle gap closes the open segment, jump to next arrival
                if (running >= 0) push_segment(running, seg_b, cur);
                running = -1;
                nxt = 32'h7fffffff;
                for (int i = 0; i < n; i++)
                    if (rem[i] != 0 && proc_arr[i] < nxt) nxt = proc_arr[i];
                cur = nxt;
                seg_b = cur;
                continue;
            end
            if (first[sel] < 0) first[sel] = cur;
            if (sel != running) begin
                if (running >= 0) push_segment(running, seg_b, cur);
                seg_b = cur;
                running = sel;
            end
            rem[sel]--;
            cur++;
            if (rem[sel] == 0) begin
                comp[sel] = cur;
                done++;
            end
        end
        if (running >= 0) push_segment(running, seg_b, cur);
        sum_t = 0; sum_w = 0; sum_r = 0;
        for (int i = 0; i < n; i++) begin
            r = '{kind: KIND_MET, default: '0};
            r.idx  = i[3:0];
            r.arr  = proc_arr[i][14:0];
            r.bur  = proc_bur[i][10:0];
            r.comp = comp[i][15:0];
            r.ta   = 24'(comp[i] - proc_arr[i]);
            r.wt   = 24'(comp[i] - proc_arr[i] - proc_bur[i]);
            r.rs   = 24'(first[i] - proc_arr[i]);
            sched_q.insert(sched_q.size(), r);
            sum_t += comp[i] - proc_arr[i];
            sum_w += comp[i] - proc_arr[i] - proc_bur[i];
            sum_r += first[i] - proc_arr[i];
        end
        r = '{kind: KIND_AVG, default: '0};
        r.ta = 24'((sum_t << 8) / n);
        r.wt = 24'((sum_w << 8) / n);
        r.rs = 24'((sum_r << 8) / n);
        r.last = 1'b1;
        sched_q.insert(sched_q.size(), r);
        n_loaded = 0;
    endfunction

    // caller stands at a rising edge; returns at the edge the item is taken, or gap edges later
    task automatic send_proc(int arr, int bur, bit fin, int gap);
        i_start <= 1'b1;
        i_arrival <= arr[14:0];
        i_burst <= bur[10:0];
        i_final_process <= fin;
        do @(posedge i_clk); while (o_busy);
        if (n_loaded < NPROC) begin
            proc_arr[n_loaded] = arr & 32'h7fff;
            proc_bur[n_loaded] = ((bur & 32'h7ff) == 0) ? 1 : (bur & 32'h7ff);
            n_loaded++;
        end
        if (fin) schedule_batch();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        t_sched_res e;
        if (i_rst_n && o_valid) begin
            if (sched_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result kind=%0d idx=%0d", o_kind, o_proc_index);
            end else begin
                e = sched_q.pop_front();
                if (o_kind !== e.kind || o_proc_index !== e.idx ||
                    o_seg_start !== e.seg_b || o_seg_end !== e.seg_e ||
                    o_arrival_out !== e.arr || o_burst_out !== e.bur ||
                    o_completion !== e.comp || o_turnaround !== e.ta ||
                    o_waiting !== e.wt || o_response !== e.rs ||
                    o_last_result !== e.last) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $write("mismatch exp: k=%0d p=%0d s=%0d e=%0d a=%0d b=%0d",
                            e.kind, e.idx, e.seg_b, e.seg_e, e.arr, e.bur);
                        $display(" c=%0d t=%0d w=%0d r=%0d l=%0d",
                            e.comp, e.ta, e.wt, e.rs, e.last);
                        $write("         got: k=%0d p=%0d s=%0d e=%0d a=%0d b=%0d",
                            o_kind, o_proc_index, o_seg_start, o_seg_end,
                            o_arrival_out, o_burst_out);
                        $display(" c=%0d t=%0d w=%0d r=%0d l=%0d",
                            o_completion, o_turnaround, o_waiting, o_response,
                            o_last_result);
                    end
                end
            end
        end
    end

    // ties on remaining time with equal arrivals, settled by load order
    task automatic test_ties();
        send_proc(5, 4, 0, 0);
        send_proc(3, 6, 0, 1);
        send_proc(5, 4, 0, 0);
        send_proc(4, 2, 1, 2);
    endtask

    // full table: zero burst, widest arrival, idle gap, ignored extra items
    task automatic test_table_full();
        for (int i = 0; i < NPROC; i++) begin
            if (i == 3) send_proc(0, 0, 0, 0);
            else if (i == 9) send_proc(32767, 3, 0, 0);
            else send_proc(10 + 2 * i, 1 + (i % 5), 0, pick_gap());
        end
        send_proc(100, 7, 0, 0);
        send_proc(200, 9, 1, 1);
    endtask

    task automatic test_long_burst();
        send_proc(32767, 2047, 1, 0);
        send_proc(0, 2047, 1, 3);
    endtask

    task automatic test_random();
        int n, base, bur, p, loaded;
        loaded = 0;
        while (loaded < 150) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 19)
                                             : $urandom_range(1, 16);
            base = $urandom_range(0, 32767);
            for (int i = 0; i < n; i++) begin
                p = $urandom_range(0, 99);
                if (p < 4) bur = 0;
                else if (p < 92) bur = $urandom_range(1, 30);
                else if (n <= 3) bur = $urandom_range(31, 2047);
                else bur = $urandom_range(31, 300);
                send_proc((base + $urandom_range(0, 60)) & 32'h7fff, bur,
                          i == n - 1, pick_gap());
            end
            loaded += (n > NPROC) ? NPROC : n;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_arrival = '0;
        i_burst = '0;
        i_final_process = 1'b0;
        n_loaded = 0;
        n_errors = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ties();
        test_table_full();
        test_long_burst();
        test_random();
        i_start <= 1'b0;
        while (sched_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (n_errors == 0 && sched_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
